>>> src/spd_pkg.sv
// Shared types and constants for the sensor packet deframer.
`timescale 1ns / 1ps

package spd_pkg;

  // Largest payload length that is accepted
  localparam int MAX_PAYLOAD = 256;

  localparam int LEN_W  = 16;
  localparam int ADDR_W = 32;
  localparam int SUM_W  = 16;
  localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

  // Header bytes
  localparam logic [7:0] HDR_BYTE0 = 8'hEF;
  localparam logic [7:0] HDR_BYTE1 = 8'h01;

  // Byte counter value on the last address byte
  localparam logic [CNT_W-1:0] ADDR_LAST = CNT_W'(3);

  // Queue between the parser and the output stage
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Output tdata width: fields rounded up to whole bytes
  localparam int M_FIELDS_W = 8 + 3 + ADDR_W + LEN_W;
  localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [3:0] {
    PH_HDR0 = 4'd0,
    PH_HDR1 = 4'd1,
    PH_ADDR = 4'd2,
    PH_TYPE = 4'd3,
    PH_LENH = 4'd4,
    PH_LENL = 4'd5,
    PH_PAY  = 4'd6,
    PH_SUMH = 4'd7,
    PH_SUML = 4'd8,
    PH_SKIP = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    V_OK    = 3'd0,
    V_HDR   = 3'd1,
    V_TRUNC = 3'd2,
    V_SUM   = 3'd3,
    V_LEN   = 3'd4
  } verdict_t;

  // Work for one received byte: an optional payload item, then an optional verdict
  typedef struct packed {
    logic              has_pay;
    logic              has_vrd;
    logic [7:0]        data;
    verdict_t          verdict;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
  } entry_t;

  // Queue status seen by the parser
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> src/spd_front.sv
// Byte parser: tracks the frame layout and turns each byte into a queue entry.
`timescale 1ns / 1ps

module spd_front
  import spd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rx_byte,
  input  logic       end_of_buffer,
  input  logic       accept,
  output logic       push,
  output entry_t     push_entry
);

  phase_t            phase, phase_next;
  logic [CNT_W-1:0]  byte_position, byte_position_next;
  logic [CNT_W-1:0]  pos_inc;
  logic [ADDR_W-1:0] address_reg, address_reg_next;
  logic [LEN_W-1:0]  length_reg, length_reg_next;
  logic [SUM_W-1:0]  running_sum, running_sum_next;
  logic [7:0]        received_sum_high, received_sum_high_next;
  logic              done, has_pay, skipping;
  verdict_t          vrd;

  assign pos_inc = byte_position + CNT_W'(1);

  // Next state and per-byte work
  always_comb begin
    phase_next             = phase;
    byte_position_next     = byte_position;
    address_reg_next       = address_reg;
    length_reg_next        = length_reg;
    running_sum_next       = running_sum;
    received_sum_high_next = received_sum_high;
    done                   = 1'b0;
    has_pay                = 1'b0;
    skipping               = 1'b0;
    vrd                    = V_OK;
    unique case (phase)
      PH_HDR0: begin
        address_reg_next   = '0;
        length_reg_next    = '0;
        running_sum_next   = '0;
        byte_position_next = '0;
        if (rx_byte != HDR_BYTE0) begin
          done = 1'b1;
          vrd  = V_HDR;
        end else begin
          phase_next = PH_HDR1;
        end
      end
      PH_HDR1: begin
        if (rx_byte != HDR_BYTE1) begin
          done = 1'b1;
          vrd  = V_HDR;
        end else begin
          phase_next         = PH_ADDR;
          byte_position_next = '0;
        end
      end
      PH_ADDR: begin
        address_reg_next   = {address_reg[ADDR_W-9:0], rx_byte};
        byte_position_next = pos_inc;
        if (byte_position == ADDR_LAST) phase_next = PH_TYPE;
      end
      PH_TYPE: begin
        running_sum_next = running_sum + SUM_W'(rx_byte);
        phase_next       = PH_LENH;
      end
      PH_LENH: begin
        length_reg_next  = {rx_byte, 8'h00};
        running_sum_next = running_sum + SUM_W'(rx_byte);
        phase_next       = PH_LENL;
      end
      PH_LENL: begin
        length_reg_next    = {length_reg[LEN_W-1:8], rx_byte};
        running_sum_next   = running_sum + SUM_W'(rx_byte);
        byte_position_next = '0;
        if (length_reg_next > MAX_LEN) begin
          done = 1'b1;
          vrd  = V_LEN;
        end else if (length_reg_next == '0) begin
          phase_next = PH_SUMH;
        end else begin
          phase_next = PH_PAY;
        end
      end
      PH_PAY: begin
        has_pay            = 1'b1;
        running_sum_next   = running_sum + SUM_W'(rx_byte);
        byte_position_next = pos_inc;
        if (LEN_W'(pos_inc) == length_reg) phase_next = PH_SUMH;
      end
      PH_SUMH: begin
        received_sum_high_next = rx_byte;
        phase_next             = PH_SUML;
      end
      PH_SUML: begin
        done = 1'b1;
        vrd  = ({received_sum_high, rx_byte} == running_sum) ? V_OK : V_SUM;
      end
      PH_SKIP: begin
        skipping = 1'b1;
        if (end_of_buffer) phase_next = PH_HDR0;
      end
      default: begin
        skipping   = 1'b1;
        phase_next = PH_HDR0;
      end
    endcase

    // End mark before the frame completed
    if (!done && !skipping && end_of_buffer) begin
      done = 1'b1;
      vrd  = V_TRUNC;
    end
    if (done) phase_next = end_of_buffer ? PH_HDR0 : PH_SKIP;
  end

  // Entry for the queue
  always_comb begin
    push_entry.has_pay = has_pay;
    push_entry.has_vrd = done;
    push_entry.data    = rx_byte;
    push_entry.verdict = vrd;
    push_entry.address = address_reg_next;
    push_entry.length  = length_reg_next;
  end

  assign push = accept && (has_pay || done);

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HDR0;
      byte_position     <= '0;
      address_reg       <= '0;
      length_reg        <= '0;
      running_sum       <= '0;
      received_sum_high <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      byte_position     <= byte_position_next;
      address_reg       <= address_reg_next;
      length_reg        <= length_reg_next;
      running_sum       <= running_sum_next;
      received_sum_high <= received_sum_high_next;
    end
  end

endmodule

>>> src/spd_queue.sv
// Short queue of parsed entries between the parser and the output stage.
`timescale 1ns / 1ps

module spd_queue
  import spd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  entry_t    push_entry,
  input  logic      pop,
  output entry_t    head,
  output q_status_t status
);

  entry_t          slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_CW-1:0] count;

  assign status.full  = (count == Q_CW'(Q_DEPTH));
  assign status.empty = (count == '0);
  assign head         = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_AW'(1);
      if (pop)  rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_AW'(1);
      if (push && !pop)      count <= count + Q_CW'(1);
      else if (pop && !push) count <= count - Q_CW'(1);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    status.full |-> !push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    status.empty |-> !pop)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CW'(Q_DEPTH))
    else $error("queue fill level out of range");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + Q_CW'(1))
    else $error("queue fill level did not follow a push");

endmodule

>>> src/spd_back.sv
// Output stage: expands queue entries into result items behind an output register.
`timescale 1ns / 1ps

module spd_back
  import spd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  entry_t              head,
  input  q_status_t           status,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,  // data_byte, verdict, frame_address, payload_length
  output logic                m_tuser,  // kind
  output logic                m_tlast   // last
);

  logic              out_valid;
  logic              out_kind;
  logic [7:0]        out_data;
  verdict_t          out_verdict;
  logic [ADDR_W-1:0] out_address;
  logic [LEN_W-1:0]  out_length;
  logic              out_last;

  logic              pay_done, pay_done_next;
  logic              load, head_valid;
  logic              nxt_kind, nxt_last;
  logic [7:0]        nxt_data;
  verdict_t          nxt_verdict;

  assign head_valid = !status.empty;
  assign load       = !out_valid || m_tready;

  // Pick the next item: payload first, then the verdict of the same entry
  always_comb begin
    pop           = 1'b0;
    pay_done_next = pay_done;
    nxt_kind      = 1'b1;
    nxt_data      = '0;
    nxt_verdict   = head.verdict;
    nxt_last      = 1'b1;
    if (head.has_pay && !pay_done) begin
      nxt_kind    = 1'b0;
      nxt_data    = head.data;
      nxt_verdict = V_OK;
      nxt_last    = 1'b0;
    end
    if (load && head_valid) begin
      if (head.has_pay && !pay_done && head.has_vrd) begin
        pay_done_next = 1'b1;
      end else begin
        pop           = 1'b1;
        pay_done_next = 1'b0;
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pay_done  <= 1'b0;
    end else begin
      pay_done <= pay_done_next;
      if (load) out_valid <= head_valid;
    end
  end

  // Output item register
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_kind    <= nxt_kind;
      out_data    <= nxt_data;
      out_verdict <= nxt_verdict;
      out_address <= head.address;
      out_length  <= head.length;
      out_last    <= nxt_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = M_DATA_W'({out_length, out_address, out_verdict, out_data});

endmodule

>>> src/sensor_packet_deframer_top.sv
// Top level of the sensor packet deframer.
//
// Input stream (s_*): one received byte per item, s_tlast marks the last byte
// of the receive buffer. Frames are EF 01, 4 address bytes, type, 2 length
// bytes (big-endian), payload, 2 checksum bytes (big-endian).
// Output stream (m_*): m_tuser = 0 carries one payload byte, m_tuser = 1 carries
// the frame verdict (ok, bad header, truncated, checksum mismatch, length too
// large) with m_tlast set. Address and length fields come along in every item.
// A result passes through the queue, then the output register, to m_tvalid.
// Throughput: one byte per cycle unless the queue is full; a payload byte that
// also ends the buffer early makes two items from one queue entry. The output
// register limits the back side, the 4-entry queue absorbs short bursts.
// Bytes after a verdict make no items until the end mark.
// Reset (rst, synchronous) empties the queue and the output register and sets
// the parser to wait for the first header byte.
// When the receiver stalls, the queue fills and s_tready drops once it is
// full; no item is lost.
`timescale 1ns / 1ps

module sensor_packet_deframer_top
  import spd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // rx_byte
  input  logic                s_tlast,   // end_of_buffer
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // data_byte, verdict, frame_address, payload_length
  output logic                m_tuser,   // kind
  output logic                m_tlast    // last
);

  logic      accept, push, pop;
  entry_t    push_entry, head;
  q_status_t status;

  assign s_tready = !status.full;
  assign accept   = s_tvalid && s_tready;

  spd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .rx_byte      (s_tdata),
    .end_of_buffer(s_tlast),
    .accept       (accept),
    .push         (push),
    .push_entry   (push_entry)
  );

  spd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .status    (status)
  );

  spd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .status  (status),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

>>> verif/testbench.sv
// Testbench for the sensor packet deframer: directed and random frames, checked item by item.
`timescale 1ns / 1ps

module testbench;
  import spd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 260;

  // One output item as the block should present it
  typedef struct {
    logic              kind;
    logic [7:0]        data;
    verdict_t          verdict;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic              last;
  } out_item_t;

  // Tracks the frame parser state and the output items still owed by the block
  class frame_tracker;
    phase_t            ph;
    logic [15:0]       pos;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [SUM_W-1:0]  sum;
    logic [7:0]        sum_hi;
    out_item_t         pending_out[$];
    int                errors;
    int                n_bytes;
    int                n_payload;
    int                n_verdict[5];

    function new();
      ph        = PH_HDR0;
      pos       = '0;
      addr      = '0;
      len       = '0;
      sum       = '0;
      sum_hi    = '0;
      errors    = 0;
      n_bytes   = 0;
      n_payload = 0;
      foreach (n_verdict[i]) n_verdict[i] = 0;
    endfunction

    task report(input string msg);
      if (errors < 40) $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
    endtask

    function void owe(logic kind, logic [7:0] d, verdict_t v, logic lst);
      out_item_t r;
      r.kind    = kind;
      r.data    = d;
      r.verdict = v;
      r.addr    = addr;
      r.len     = len;
      r.last    = lst;
      pending_out.push_back(r);
    endfunction

    // Advance the parser by one accepted byte and queue what it produces
    function void take_byte(logic [7:0] b, logic eob);
      logic     done;
      verdict_t v;
      done = 1'b0;
      v    = V_OK;
      n_bytes++;
      case (ph)
        PH_HDR0: begin
          addr = '0;
          len  = '0;
          sum  = '0;
          pos  = '0;
          if (b != HDR_BYTE0) begin
            done = 1'b1;
            v    = V_HDR;
          end else begin
            ph = PH_HDR1;
          end
        end
        PH_HDR1: begin
          if (b != HDR_BYTE1) begin
            done = 1'b1;
            v    = V_HDR;
          end else begin
            ph  = PH_ADDR;
            pos = '0;
          end
        end
        PH_ADDR: begin
          addr = {addr[ADDR_W-9:0], b};
          pos  = pos + 16'd1;
          if (pos >= 16'd4) ph = PH_TYPE;
        end
        PH_TYPE: begin
          sum = sum + SUM_W'(b);
          ph  = PH_LENH;
        end
        PH_LENH: begin
          len = {b, 8'h00};
          sum = sum + SUM_W'(b);
          ph  = PH_LENL;
        end
        PH_LENL: begin
          len[7:0] = b;
          sum      = sum + SUM_W'(b);
          pos      = '0;
          if (len > MAX_LEN) begin
            done = 1'b1;
            v    = V_LEN;
          end else begin
            ph = (len == '0) ? PH_SUMH : PH_PAY;
          end
        end
        PH_PAY: begin
          owe(1'b0, b, V_OK, 1'b0);
          n_payload++;
          sum = sum + SUM_W'(b);
          pos = pos + 16'd1;
          if (pos >= len) ph = PH_SUMH;
        end
        PH_SUMH: begin
          sum_hi = b;
          ph     = PH_SUML;
        end
        PH_SUML: begin
          done = 1'b1;
          v    = ({sum_hi, b} == sum) ? V_OK : V_SUM;
        end
        default: begin
          // skipping the rest of the buffer
          if (eob) ph = PH_HDR0;
          return;
        end
      endcase

      if (!done && eob) begin
        done = 1'b1;
        v    = V_TRUNC;
      end
      if (done) begin
        owe(1'b1, 8'h00, v, 1'b1);
        n_verdict[int'(v)]++;
        ph = eob ? PH_HDR0 : PH_SKIP;
      end
    endfunction

    // Compare one output item with the oldest one owed
    task match_output(input logic kind, input logic [M_DATA_W-1:0] td, input logic lst);
      out_item_t         want;
      logic [7:0]        d;
      logic [2:0]        v;
      logic [ADDR_W-1:0] a;
      logic [LEN_W-1:0]  l;
      d = td[7:0];
      v = td[10:8];
      a = td[11 +: ADDR_W];
      l = td[11+ADDR_W +: LEN_W];
      if (pending_out.size() == 0) begin
        report($sformatf("item with nothing owed: kind %0d tdata %h last %0d", kind, td, lst));
        return;
      end
      want = pending_out.pop_front();
      if (kind !== want.kind)
        report($sformatf("kind %0d, want %0d", kind, want.kind));
      if (d !== want.data)
        report($sformatf("data byte %h, want %h", d, want.data));
      if (v !== want.verdict)
        report($sformatf("verdict %0d, want %0d", v, want.verdict));
      if (a !== want.addr)
        report($sformatf("address %h, want %h", a, want.addr));
      if (l !== want.len)
        report($sformatf("length %h, want %h", l, want.len));
      if (lst !== want.last)
        report($sformatf("last %0d, want %0d", lst, want.last));
    endtask

    task close_out();
      if (pending_out.size() != 0)
        report($sformatf("%0d items never came out", pending_out.size()));
    endtask
  endclass

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata  = 8'h00;
  logic                s_tlast  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tuser;
  logic                m_tlast;

  int           gap_pct     = 0;
  int           stall_pct   = 0;
  int           cycle_count = 0;
  logic [7:0]   byte_q[$];
  bit           end_q[$];
  frame_tracker trk = new();

  sensor_packet_deframer_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watch both handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) trk.take_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) trk.match_output(m_tuser, m_tdata, m_tlast);
    end
  end

  // Run watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("testbench: done, errors");
    $finish;
  end

  function automatic void push_byte(logic [7:0] b, bit e);
    byte_q.push_back(b);
    end_q.push_back(e);
  endfunction

  // Junk after a verdict, end mark on the final one
  function automatic void add_trail(int n);
    int i;
    for (i = 0; i < n; i++) push_byte(8'($urandom), i == n - 1);
  endfunction

  // Full frame; a length over the limit stops after the length bytes.
  // fill < 0 gives random payload bytes.
  function automatic void add_frame(logic [ADDR_W-1:0] a, logic [7:0] typ,
                                    logic [LEN_W-1:0] len, int fill, bit bad_sum, int trail);
    logic [SUM_W-1:0] cs;
    logic [7:0]       p;
    int               i;
    push_byte(HDR_BYTE0, 1'b0);
    push_byte(HDR_BYTE1, 1'b0);
    for (i = 3; i >= 0; i--) push_byte(a[8*i +: 8], 1'b0);
    push_byte(typ, 1'b0);
    push_byte(len[15:8], 1'b0);
    cs = SUM_W'(typ) + SUM_W'(len[15:8]) + SUM_W'(len[7:0]);
    if (len > MAX_LEN) begin
      push_byte(len[7:0], trail == 0);
    end else begin
      push_byte(len[7:0], 1'b0);
      for (i = 0; i < int'(len); i++) begin
        p = (fill < 0) ? 8'($urandom) : 8'(fill);
        push_byte(p, 1'b0);
        cs = cs + SUM_W'(p);
      end
      if (bad_sum) cs = cs ^ (SUM_W'(1) << $urandom_range(15));
      push_byte(cs[15:8], 1'b0);
      push_byte(cs[7:0], trail == 0);
    end
    add_trail(trail);
  endfunction

  function automatic void add_bad_header(bit second, int trail);
    logic [7:0] b;
    b = 8'($urandom);
    if (!second) begin
      if (b == HDR_BYTE0) b = b ^ 8'h01;
      push_byte(b, trail == 0);
    end else begin
      push_byte(HDR_BYTE0, 1'b0);
      if (b == HDR_BYTE1) b = b ^ 8'h80;
      push_byte(b, trail == 0);
    end
    add_trail(trail);
  endfunction

  // End the buffer early at start + off, dropping the rest
  function automatic void cut_frame(int start, int off);
    while (byte_q.size() > start + off + 1) begin
      void'(byte_q.pop_back());
      void'(end_q.pop_back());
    end
    end_q[start + off] = 1'b1;
  endfunction

  // Mostly short payloads, now and then the longest ones
  function automatic logic [LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 85) return LEN_W'($urandom_range(1, 12));
    if (r < 98) return LEN_W'($urandom_range(13, 64));
    return LEN_W'($urandom_range(200, MAX_PAYLOAD));
  endfunction

  function automatic logic [LEN_W-1:0] pick_big_len();
    int r;
    r = $urandom_range(9);
    if (r == 0) return MAX_LEN + 16'd1;
    if (r == 1) return 16'hFFFF;
    return LEN_W'($urandom_range(MAX_PAYLOAD + 1, 65535));
  endfunction

  function automatic void add_random_frame();
    int r;
    int n;
    int i;
    r = $urandom_range(99);
    if (r < 50) begin
      add_frame($urandom, 8'($urandom), pick_len(), -1, 1'b0,
                ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
    end else if (r < 62) begin
      add_frame($urandom, 8'($urandom), pick_len(), -1, 1'b1, $urandom_range(1));
    end else if (r < 74) begin
      add_frame($urandom, 8'($urandom), pick_len(), -1, 1'b0, 0);
      cut_frame(0, $urandom_range(byte_q.size() - 2));
    end else if (r < 82) begin
      add_bad_header(1'($urandom_range(1)), $urandom_range(3));
    end else if (r < 90) begin
      add_frame($urandom, 8'($urandom), pick_big_len(), -1, 1'b0, $urandom_range(3));
    end else begin
      // line noise, end marks anywhere or missing
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++)
        push_byte(8'($urandom),
                  (i == n - 1) ? 1'($urandom_range(1)) : ($urandom_range(3) == 0));
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit eob);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eob;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic flush_bytes();
    logic [7:0] b;
    bit         e;
    while (byte_q.size() != 0) begin
      b = byte_q.pop_front();
      e = end_q.pop_front();
      send_byte(b, e);
    end
  endtask

  // Stop sending and let every owed item come out
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (trk.pending_out.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_phase(input int sender_gap, input int rcv_stall, input bit hold);
    int goal;
    int half;
    gap_pct   = sender_gap;
    stall_pct = rcv_stall;
    goal      = trk.n_bytes + PHASE_BYTES;
    half      = trk.n_bytes + PHASE_BYTES / 2;
    while (trk.n_bytes < goal) begin
      add_random_frame();
      flush_bytes();
      if (hold && trk.n_bytes >= half) begin
        hold = 1'b0;
        wait_drained();
      end
    end
    wait_drained();
  endtask

  initial begin
    int i;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed cases
    gap_pct   = 20;
    stall_pct = 20;
    add_frame(32'h0000_0000, 8'h00, 16'd0, -1, 1'b0, 0);         // empty payload
    add_frame(32'hFFFF_FFFF, 8'hFF, MAX_LEN, 8'hFF, 1'b0, 0);    // longest, sum wraps to zero
    add_frame(32'h1234_5678, 8'($urandom), 16'd1, -1, 1'b0, 3);  // trailing bytes skipped
    add_frame($urandom, 8'($urandom), 16'd2, -1, 1'b1, 0);       // checksum mismatch
    add_bad_header(1'b0, 0);                                     // bad first byte with end mark
    add_bad_header(1'b1, 2);                                     // bad second byte
    add_frame($urandom, 8'($urandom), MAX_LEN + 16'd1, -1, 1'b0, 0); // too long beats truncation
    add_frame($urandom, 8'($urandom), 16'hFFFF, -1, 1'b0, 2);
    add_frame($urandom, 8'($urandom), 16'd4, -1, 1'b0, 0);
    cut_frame(byte_q.size() - 15, 4);                            // end inside the address
    add_frame($urandom, 8'($urandom), 16'd3, -1, 1'b0, 0);
    cut_frame(byte_q.size() - 14, 10);                           // end on a payload byte
    add_frame($urandom, 8'($urandom), 16'd0, -1, 1'b0, 0);
    cut_frame(byte_q.size() - 11, 9);                            // end on first checksum byte
    add_frame($urandom, 8'($urandom), 16'd0, -1, 1'b0, 0);
    cut_frame(byte_q.size() - 11, 0);                            // end on first header byte
    add_frame($urandom, 8'($urandom), 16'd0, -1, 1'b0, 0);
    cut_frame(byte_q.size() - 11, 1);                            // end on second header byte
    flush_bytes();
    wait_drained();

    // Random frames under each idling pattern
    run_phase(0, 0, 1'b1);
    run_phase(61, 0, 1'b0);
    run_phase(0, 61, 1'b1);
    run_phase(19, 19, 1'b0);

    // Final drain with a bound
    for (i = 0; i < 20000 && trk.pending_out.size() != 0; i++) @(posedge clk);
    repeat (10) @(posedge clk);
    trk.close_out();

    $display("run covered %0d bytes, %0d payload items in %0d cycles", trk.n_bytes,
             trk.n_payload, cycle_count);
    $display("verdicts ok %0d, bad header %0d, truncated %0d, sum mismatch %0d, too long %0d",
             trk.n_verdict[0], trk.n_verdict[1], trk.n_verdict[2], trk.n_verdict[3],
             trk.n_verdict[4]);
    if (trk.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
